// ===== design/vcpa_pkg.sv =====
// Shared types and constants for the voice channel pool allocator.
package vcpa_pkg;

  // Pool size and source key size
  localparam int CHANNELS       = 24;
  localparam int SOURCE_ID_BITS = 16;

  // Fixed field widths of the request and result items
  localparam int OP_W     = 2;
  localparam int SRC_W    = 16;
  localparam int CH_W     = 5;
  localparam int ACTIVE_W = 5;

  // Derived widths
  localparam int KEY_W   = (SOURCE_ID_BITS < SRC_W) ? SOURCE_ID_BITS : SRC_W;
  localparam int PTR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W   = $clog2(CHANNELS + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 16;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN  = 2'd0,
    OP_ADD     = 2'd1,
    OP_FIND    = 2'd2,
    OP_RELEASE = 2'd3
  } vcpa_op_e;

  // Request payload, lowest field last in the packed list
  typedef struct packed {
    logic [IN_W-SRC_W-CH_W-2:0] pad;
    logic                       stop_on_release;
    logic [CH_W-1:0]            channel;
    logic [SRC_W-1:0]           source_id;
  } vcpa_in_t;

  // Result payload, lowest field last in the packed list
  typedef struct packed {
    logic [OUT_W-ACTIVE_W-CH_W-4:0] pad;
    logic [ACTIVE_W-1:0]            active_count;
    logic                           stop_source;
    logic                           was_playing;
    logic [CH_W-1:0]                channel_out;
    logic                           ok;
  } vcpa_out_t;

  // Table update command
  typedef struct packed {
    logic add;
    logic clear;
  } vcpa_tbl_cmd_t;

  // Table lookup status
  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] channel;
    logic            full;
  } vcpa_lookup_t;

endpackage

// ===== design/vcpa_table.sv =====
// Associative table of playing sources: parallel key compare and slot update.
module vcpa_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vcpa_pkg::KEY_W-1:0]  key_i,
  input  logic [vcpa_pkg::CH_W-1:0]   channel_i,
  input  vcpa_pkg::vcpa_tbl_cmd_t     cmd_i,
  output vcpa_pkg::vcpa_lookup_t      lookup_o
);

  logic [vcpa_pkg::CHANNELS-1:0] valid_q;
  logic [vcpa_pkg::KEY_W-1:0]    src_q  [vcpa_pkg::CHANNELS];
  logic [vcpa_pkg::CH_W-1:0]     chan_q [vcpa_pkg::CHANNELS];

  logic                          hit;
  logic [vcpa_pkg::PTR_W-1:0]    hit_idx;
  logic [vcpa_pkg::CH_W-1:0]     hit_chan;
  logic                          free_found;
  logic [vcpa_pkg::PTR_W-1:0]    free_idx;

  // Compare every valid entry and pick the lowest match and the lowest free slot
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    hit_chan   = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < vcpa_pkg::CHANNELS; i++) begin
      if (!hit && valid_q[i] && (src_q[i] == key_i)) begin
        hit      = 1'b1;
        hit_idx  = vcpa_pkg::PTR_W'(i);
        hit_chan = chan_q[i];
      end
      if (!free_found && !valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = vcpa_pkg::PTR_W'(i);
      end
    end
  end

  assign lookup_o.hit     = hit;
  assign lookup_o.channel = hit_chan;
  assign lookup_o.full    = !free_found;

  // Set a slot on add, drop it on release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.add && !hit && free_found) begin
        valid_q[free_idx] <= 1'b1;
      end else if (cmd_i.clear && hit) begin
        valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  // Write key and channel into the new slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && !hit && free_found) begin
      src_q[free_idx]  <= key_i;
      chan_q[free_idx] <= channel_i;
    end
  end

endmodule

// ===== design/voice_channel_pool_allocator_core.sv =====
// Top level: request register, free channel list, table control and result register.
// Flow: a request is accepted into the input register, resolved from there, and its result is
// registered into the result register once that register is empty or being taken by the sink.
// Throughput: one request per cycle while the sink holds m_axis_tready; the table compare and the
// free list pointer update are both resolved combinationally between the input and result registers.
// Reset: free list holds every channel in ascending order, table empty, count zero.
module voice_channel_pool_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: source_id[15:0], channel[20:16], stop_on_release[21], zero pad [23:22]
  input  logic [vcpa_pkg::IN_W-1:0]   s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [vcpa_pkg::OP_W-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: ok[0], channel_out[5:1], was_playing[6], stop_source[7],
  //        active_count[12:8], zero pad [15:13]
  output logic [vcpa_pkg::OUT_W-1:0]  m_axis_tdata
);

  // Input register
  logic                        in_vld_q;
  vcpa_pkg::vcpa_op_e          op_q;
  logic [vcpa_pkg::KEY_W-1:0]  key_q;
  logic [vcpa_pkg::CH_W-1:0]   chan_q;
  logic                        stop_q;

  // Free list and counters
  logic [vcpa_pkg::CH_W-1:0]   fifo_q [vcpa_pkg::CHANNELS];
  logic [vcpa_pkg::PTR_W-1:0]  head_q, head_d;
  logic [vcpa_pkg::CNT_W-1:0]  free_cnt_q, free_cnt_d;
  logic [vcpa_pkg::CNT_W-1:0]  active_q, active_d;
  logic [vcpa_pkg::SUM_W-1:0]  tail_sum;
  logic [vcpa_pkg::SUM_W-1:0]  tail_wrap;
  logic                        push;
  logic                        pop;

  // Result register
  logic                        out_vld_q;
  vcpa_pkg::vcpa_out_t         res_q, res_d;

  logic                        advance;
  vcpa_pkg::vcpa_in_t          in_pl;
  vcpa_pkg::vcpa_tbl_cmd_t     tbl_cmd;
  vcpa_pkg::vcpa_lookup_t      lookup;

  assign in_pl         = vcpa_pkg::vcpa_in_t'(s_axis_tdata);
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = vcpa_pkg::OUT_W'(res_q);

  // Hold the request until the result stage can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= vcpa_pkg::vcpa_op_e'(s_axis_tuser);
      key_q  <= in_pl.source_id[vcpa_pkg::KEY_W-1:0];
      chan_q <= in_pl.channel;
      stop_q <= in_pl.stop_on_release;
    end
  end

  // Table of playing sources
  assign tbl_cmd.add   = advance && (op_q == vcpa_pkg::OP_ADD);
  assign tbl_cmd.clear = advance && (op_q == vcpa_pkg::OP_RELEASE);

  vcpa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (key_q),
    .channel_i (chan_q),
    .cmd_i     (tbl_cmd),
    .lookup_o  (lookup)
  );

  // Tail slot of the free list, wrapped once
  assign tail_sum  = vcpa_pkg::SUM_W'(head_q) + vcpa_pkg::SUM_W'(free_cnt_q);
  assign tail_wrap = (tail_sum >= vcpa_pkg::SUM_W'(vcpa_pkg::CHANNELS))
                     ? (tail_sum - vcpa_pkg::SUM_W'(vcpa_pkg::CHANNELS)) : tail_sum;

  // Resolve the operation
  always_comb begin
    res_d      = '0;
    pop        = 1'b0;
    push       = 1'b0;
    head_d     = head_q;
    free_cnt_d = free_cnt_q;
    active_d   = active_q;
    unique case (op_q)
      vcpa_pkg::OP_ASSIGN: begin
        if (lookup.hit) begin
          res_d.ok          = 1'b1;
          res_d.was_playing = 1'b1;
          res_d.channel_out = lookup.channel;
        end else if (free_cnt_q != '0) begin
          res_d.ok          = 1'b1;
          res_d.channel_out = fifo_q[head_q];
          pop               = advance;
        end
      end
      vcpa_pkg::OP_ADD: begin
        if (!lookup.hit && !lookup.full) begin
          res_d.ok = 1'b1;
          active_d = active_q + vcpa_pkg::CNT_W'(1);
        end
      end
      vcpa_pkg::OP_FIND: begin
        if (lookup.hit) begin
          res_d.ok          = 1'b1;
          res_d.channel_out = lookup.channel;
        end
      end
      vcpa_pkg::OP_RELEASE: begin
        if (lookup.hit) begin
          res_d.ok          = 1'b1;
          res_d.channel_out = lookup.channel;
          res_d.stop_source = stop_q;
          active_d          = active_q - vcpa_pkg::CNT_W'(1);
          push              = advance &&
                              (free_cnt_q != vcpa_pkg::CNT_W'(vcpa_pkg::CHANNELS));
        end
      end
      default: ;
    endcase
    if (pop) begin
      head_d     = (head_q == vcpa_pkg::PTR_W'(vcpa_pkg::CHANNELS - 1))
                   ? '0 : head_q + vcpa_pkg::PTR_W'(1);
      free_cnt_d = free_cnt_q - vcpa_pkg::CNT_W'(1);
    end
    if (push) begin
      free_cnt_d = free_cnt_q + vcpa_pkg::CNT_W'(1);
    end
    res_d.active_count = vcpa_pkg::ACTIVE_W'(active_d);
  end

  // Advance free list pointers and the active count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      free_cnt_q <= vcpa_pkg::CNT_W'(vcpa_pkg::CHANNELS);
      active_q   <= '0;
    end else if (advance) begin
      head_q     <= head_d;
      free_cnt_q <= free_cnt_d;
      active_q   <= active_d;
    end
  end

  // Free list storage: ascending channels after reset, push at the tail
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vcpa_pkg::CHANNELS; i++) begin
        fifo_q[i] <= vcpa_pkg::CH_W'(i);
      end
    end else if (push) begin
      fifo_q[tail_wrap[vcpa_pkg::PTR_W-1:0]] <= lookup.channel;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule
